// File: sv/utfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfe_pkg
// Shared types and constants of the UTF-8 encoder with surrogate pairing.
// ----------------------------------------------------------------------------
package utfe_pkg;

   // Configuration register indexes.
   localparam logic CSR_ALLOW_PAIRS = 1'b0;
   localparam logic CSR_PER_ITEM    = 1'b1;

   // Code point limits.
   localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
   localparam logic [31:0] HIGH_FIRST  = 32'h0000_D800;
   localparam logic [31:0] HIGH_LAST   = 32'h0000_DBFF;
   localparam logic [31:0] LOW_FIRST   = 32'h0000_DC00;
   localparam logic [31:0] LOW_LAST    = 32'h0000_DFFF;
   localparam logic [31:0] ONE_MAX     = 32'h0000_007F;
   localparam logic [31:0] TWO_MAX     = 32'h0000_07FF;
   localparam logic [31:0] THREE_MAX   = 32'h0000_FFFF;
   localparam logic [20:0] PLANE1_BASE = 21'h01_0000;

   // Byte length codes (number of bytes minus one).
   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   // UTF-8 byte prefixes.
   localparam logic [1:0] PFX_CONT  = 2'b10;
   localparam logic [2:0] PFX_LEAD2 = 3'b110;
   localparam logic [3:0] PFX_LEAD3 = 4'b1110;
   localparam logic [4:0] PFX_LEAD4 = 5'b11110;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Input transaction.
   typedef struct packed {
      logic signed [31:0] code_value;
      logic               end_of_string;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       last_of_item;
      logic       invalid;
      logic       string_end;
   } rsp_type;

   // Classified item passed from the front to the back.
   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  len;
      logic        present;
      logic        invalid;
      logic        closes;
   } item_type;

endpackage

// File: sv/utf8_encoder_with_surrogate_pairs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_encoder_with_surrogate_pairs_core
// UTF-8 encoder with optional surrogate pairing, string and per-item modes.
// ----------------------------------------------------------------------------
// The first byte of an item passes the queue and then the output register of
// the back end before it is on the result ports.
// Throughput: one result per cycle while results are popped, set by the
// byte serializer in the back end; each byte, or an empty item, is one result.
// Reset clears the configuration, the surrogate and error state, the queue
// and the output valid flag; the block accepts items once reset is released.
module utf8_encoder_with_surrogate_pairs_core
   import utfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   input  logic    csr_write_en,
   input  logic    csr_index,
   input  logic    csr_write_data
);

   logic     accept;
   logic     item_write;
   item_type item_data;
   item_type head;
   logic     head_empty;
   logic     head_pop;

   // An input transaction is taken whenever the queue has room.
   assign accept = req_push && !req_full;

   utfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .req_data       (req_data),
      .item_write     (item_write),
      .item_data      (item_data)
   );

   utfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_write),
      .wr_data (item_data),
      .rd_en   (head_pop),
      .rd_data (head),
      .full    (req_full),
      .empty   (head_empty)
   );

   utfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// File: sv/utfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfe_front
// Accepts code values, tracks surrogates and errors, and queues work items.
// ----------------------------------------------------------------------------
module utfe_front
   import utfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_write_en,
   input  logic     csr_index,
   input  logic     csr_write_data,
   input  logic     accept,
   input  req_type  req_data,
   output logic     item_write,
   output item_type item_data
);

   logic       allow_pairs_ff, allow_pairs_in;
   logic       per_item_ff, per_item_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       held_valid_ff, held_valid_in;
   logic       error_ff, error_in;

   logic [31:0] value;
   logic        eos;
   logic        negative;
   logic        too_big;
   logic        is_high;
   logic        is_low;
   logic        is_bad;
   logic [1:0]  plain_len;
   logic [20:0] pair_cp;
   logic        emit;

   // Classification of the incoming value.
   always_comb begin
      value     = req_data.code_value;
      eos       = req_data.end_of_string;
      negative  = value[31];
      too_big   = !negative && (value > CP_MAX);
      is_high   = (value >= HIGH_FIRST) && (value <= HIGH_LAST);
      is_low    = (value >= LOW_FIRST) && (value <= LOW_LAST);
      is_bad    = negative || too_big;
      pair_cp   = PLANE1_BASE + {1'b0, held_bits_ff, value[9:0]};
      if (value <= ONE_MAX) begin
         plain_len = LEN_ONE;
      end else if (value <= TWO_MAX) begin
         plain_len = LEN_TWO;
      end else if (value <= THREE_MAX) begin
         plain_len = LEN_THREE;
      end else begin
         plain_len = LEN_FOUR;
      end
   end

   // Configuration writes.
   always_comb begin
      allow_pairs_in = allow_pairs_ff;
      per_item_in    = per_item_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALLOW_PAIRS: allow_pairs_in = csr_write_data;
            CSR_PER_ITEM:    per_item_in    = csr_write_data;
            default:         allow_pairs_in = allow_pairs_ff;
         endcase
      end
   end

   // Surrogate and error tracking, and the work item for the back end.
   always_comb begin
      held_bits_in         = held_bits_ff;
      held_valid_in        = held_valid_ff;
      error_in             = error_ff;
      emit                 = 1'b0;
      item_data.code_point = value[20:0];
      item_data.len        = plain_len;
      item_data.present    = 1'b0;
      item_data.invalid    = 1'b0;
      item_data.closes     = 1'b1;
      item_write           = 1'b0;

      if (per_item_ff) begin
         // Every item is a string of its own.
         held_bits_in  = '0;
         held_valid_in = 1'b0;
         error_in      = 1'b0;
         item_write    = accept;
         if (is_bad || is_high || is_low) begin
            item_data.invalid = 1'b1;
            item_data.len     = LEN_ONE;
         end else if (value == '0) begin
            item_data.len = LEN_ONE;
         end else begin
            item_data.present = 1'b1;
         end
      end else begin
         if (!error_ff) begin
            priority if (held_valid_ff) begin
               if (is_low) begin
                  emit                 = 1'b1;
                  item_data.code_point = pair_cp;
                  item_data.len        = LEN_FOUR;
               end else begin
                  error_in = 1'b1;
               end
               held_valid_in = 1'b0;
               held_bits_in  = '0;
            end else if (is_bad || is_low) begin
               error_in = 1'b1;
            end else if (is_high) begin
               if (!allow_pairs_ff || eos) begin
                  error_in = 1'b1;
               end else begin
                  held_valid_in = 1'b1;
                  held_bits_in  = value[9:0];
               end
            end else if (value != '0) begin
               emit = 1'b1;
            end
         end
         item_data.present = emit;
         item_data.invalid = error_in;
         item_data.closes  = eos;
         if (!emit) begin
            item_data.len = LEN_ONE;
         end
         item_write = accept && (emit || eos);
         // The end of a string clears all string state.
         if (eos) begin
            held_valid_in = 1'b0;
            held_bits_in  = '0;
            error_in      = 1'b0;
         end
      end

      if (!accept) begin
         held_bits_in  = held_bits_ff;
         held_valid_in = held_valid_ff;
         error_in      = error_ff;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_pairs_ff <= 1'b0;
         per_item_ff    <= 1'b0;
         held_bits_ff   <= '0;
         held_valid_ff  <= 1'b0;
         error_ff       <= 1'b0;
      end else begin
         allow_pairs_ff <= allow_pairs_in;
         per_item_ff    <= per_item_in;
         held_bits_ff   <= held_bits_in;
         held_valid_ff  <= held_valid_in;
         error_ff       <= error_in;
      end
   end

endmodule

// File: sv/utfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfe_queue
// Short register queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module utfe_queue
   import utfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     full,
   output logic     empty
);

   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] DEPTH_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_wr;
   logic                     do_rd;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill count above depth");

   // A write into a full queue must not happen.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full))
      else $error("write into full queue");

   // A read from an empty queue must not happen.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && empty))
      else $error("read from empty queue");

endmodule

// File: sv/utfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfe_back
// Turns queued work items into UTF-8 bytes, one result per cycle while results are popped.
// ----------------------------------------------------------------------------
module utfe_back
   import utfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  item_type head,
   input  logic     head_empty,
   output logic     head_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       last;

   // Byte at position idx of a code point that takes len+1 bytes.
   function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len,
                                             logic [1:0] idx);
      logic [1:0] pos;
      logic [7:0] b;
      pos = len - idx;
      if (idx == '0) begin
         unique case (len)
            LEN_ONE:   b = {1'b0, cp[6:0]};
            LEN_TWO:   b = {PFX_LEAD2, cp[10:6]};
            LEN_THREE: b = {PFX_LEAD3, cp[15:12]};
            default:   b = {PFX_LEAD4, cp[20:18]};
         endcase
      end else begin
         unique case (pos)
            2'd0:    b = {PFX_CONT, cp[5:0]};
            2'd1:    b = {PFX_CONT, cp[11:6]};
            default: b = {PFX_CONT, cp[17:12]};
         endcase
      end
      return b;
   endfunction

   assign load      = !head_empty && (!out_valid_ff || rsp_pop);
   assign last      = (byte_idx_ff == head.len);
   assign head_pop  = load && last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Byte sequencing and output register.
   always_comb begin
      byte_idx_in  = byte_idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in        = 1'b1;
         byte_idx_in         = last ? '0 : byte_idx_ff + 1'b1;
         out_in.out_byte     = head.present ?
                               utf8_byte(head.code_point, head.len, byte_idx_ff) : 8'h00;
         out_in.byte_present = head.present;
         out_in.last_of_item = last;
         out_in.invalid      = head.invalid;
         out_in.string_end   = last && head.closes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         byte_idx_ff  <= byte_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // The byte counter never runs past the length of the item at the head.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> (byte_idx_ff <= head.len))
      else $error("byte index beyond item length");

   // A string only closes on the final result of an item.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_data.string_end) |-> rsp_data.last_of_item)
      else $error("string end without last of item");

   // An empty result is always the only result of its item.
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_data.byte_present) |->
         (rsp_data.last_of_item && rsp_data.out_byte == 8'h00))
      else $error("empty result not alone");

endmodule

// File: test/tb_utf8_encoder_with_surrogate_pairs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_encoder_with_surrogate_pairs_core
// Self-checking bench for the UTF-8 encoder. A table of directed items covers
// the byte-length boundaries, zero, the invalid ranges, the surrogate cases
// and both modes. Random phases follow, each under its own pair of register
// settings. Every accepted input transaction is run through an encoder
// written here, and each result transaction is checked field by field against
// the oldest byte pending. Both sides stall at random until the last phase.
// ----------------------------------------------------------------------------
module tb_utf8_encoder_with_surrogate_pairs_core;
   import utfe_pkg::*;

   localparam int unsigned CLK_PERIOD    = 4;
   localparam int unsigned RESET_CYCLES  = 5;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT   = 20000;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned PHASE_ITEMS   = 80;

   // Single results that can be typed in directly.
   localparam rsp_type EMPTY_CLOSE = {8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam rsp_type BAD_CLOSE   = {8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam rsp_type NO_WANT     = '0;

   typedef enum logic [1:0] {ROW_ITEM, ROW_ALLOW, ROW_MODE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  code;
      bit           eos;
      bit           typed;
      rsp_type      want;
   } dir_row_type;

   logic    clock          = 1'b0;
   logic    reset          = 1'b1;
   logic    req_push       = 1'b0;
   logic    req_full;
   req_type req_data       = '0;
   logic    rsp_empty;
   logic    rsp_pop        = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en   = 1'b0;
   logic    csr_index      = 1'b0;
   logic    csr_write_data = 1'b0;

   // Shadow of the configuration and of the encoder state.
   bit          allow_q;
   bit          per_item_q;
   bit          held_q;
   bit          err_q;
   logic [9:0]  held_bits_q;

   rsp_type     pending_bytes [$];
   dir_row_type dir_rows [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_left     = 0;
   bit          idle_on        = 1'b1;
   rsp_type     want;

   utf8_encoder_with_surrogate_pairs_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[utf8_encoder_with_surrogate_pairs_core] ERROR");
         $finish;
      end
   end

   // One line per mismatch, and a running count.
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp_val);
      $display("mismatch at cycle %0d: %s got 'h%0h want 'h%0h",
               cycle_count, what, got, exp_val);
      mismatch_count++;
   endtask

   // Bytes of one code point in 1..0x10FFFF; returns the byte count.
   function automatic int unsigned utf8_encode(input logic [20:0] cp,
                                               output logic [7:0] b [4]);
      b = '{default: 8'h00};
      if (cp <= ONE_MAX) begin
         b[0] = cp[7:0];
         return 1;
      end
      if (cp <= TWO_MAX) begin
         b[0] = {PFX_LEAD2, cp[10:6]};
         b[1] = {PFX_CONT, cp[5:0]};
         return 2;
      end
      if (cp <= THREE_MAX) begin
         b[0] = {PFX_LEAD3, cp[15:12]};
         b[1] = {PFX_CONT, cp[11:6]};
         b[2] = {PFX_CONT, cp[5:0]};
         return 3;
      end
      b[0] = {PFX_LEAD4, cp[20:18]};
      b[1] = {PFX_CONT, cp[17:12]};
      b[2] = {PFX_CONT, cp[11:6]};
      b[3] = {PFX_CONT, cp[5:0]};
      return 4;
   endfunction

   // Queue the results of one item; an item without bytes that closes a
   // string still yields one empty result.
   function automatic void queue_bytes(input logic [7:0] b [4], input int unsigned n,
                                       input bit inv, input bit closes);
      rsp_type r;
      if (n == 0) begin
         if (closes)
            pending_bytes.push_back({8'h00, 1'b0, 1'b1, inv, 1'b1});
         return;
      end
      for (int unsigned i = 0; i < n; i++) begin
         r = {b[i], 1'b1, i == n - 1, inv, closes && (i == n - 1)};
         pending_bytes.push_back(r);
      end
   endfunction

   // Expected bytes of one accepted item, with the surrogate and error state.
   function automatic void encode_item(input logic [31:0] v, input bit eos);
      bit          too_big;
      bit          is_high;
      bit          is_low;
      bit          bad;
      logic [7:0]  b [4];
      logic [20:0] cp;
      int unsigned n;
      too_big = !v[31] && v > CP_MAX;
      is_high = v >= HIGH_FIRST && v <= HIGH_LAST;
      is_low  = v >= LOW_FIRST && v <= LOW_LAST;
      n = 0;
      b = '{default: 8'h00};

      // Each item is a string of its own; surrogates never pair.
      if (per_item_q) begin
         held_q = 1'b0;
         held_bits_q = '0;
         err_q = 1'b0;
         bad = v[31] || too_big || is_high || is_low;
         if (!bad && v != 0)
            n = utf8_encode(v[20:0], b);
         queue_bytes(b, n, bad, 1'b1);
         return;
      end

      // String mode: once the string is in error nothing more is encoded.
      if (!err_q) begin
         if (held_q) begin
            if (is_low) begin
               cp = PLANE1_BASE + {held_bits_q, v[9:0]};
               n = utf8_encode(cp, b);
            end else begin
               err_q = 1'b1;
            end
            held_q = 1'b0;
            held_bits_q = '0;
         end else if (v[31] || too_big || is_low) begin
            err_q = 1'b1;
         end else if (is_high) begin
            if (!allow_q || eos) begin
               err_q = 1'b1;
            end else begin
               held_q = 1'b1;
               held_bits_q = v[9:0];
            end
         end else if (v != 0) begin
            n = utf8_encode(v[20:0], b);
         end
      end
      queue_bytes(b, n, err_q, eos);
      if (eos) begin
         held_q = 1'b0;
         held_bits_q = '0;
         err_q = 1'b0;
      end
   endfunction

   // Result side: check each accepted transaction, then pick the next pop.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            flag_mismatch("result with nothing pending", rsp_data, 0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               flag_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
            if (rsp_data.byte_present !== want.byte_present)
               flag_mismatch("byte_present", rsp_data.byte_present, want.byte_present);
            if (rsp_data.last_of_item !== want.last_of_item)
               flag_mismatch("last_of_item", rsp_data.last_of_item, want.last_of_item);
            if (rsp_data.invalid !== want.invalid)
               flag_mismatch("invalid", rsp_data.invalid, want.invalid);
            if (rsp_data.string_end !== want.string_end)
               flag_mismatch("string_end", rsp_data.string_end, want.string_end);
         end
      end
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_pop <= 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Send one input transaction and record what it should produce.
   task automatic send_item(input logic [31:0] code, input bit eos,
                            input bit typed, input rsp_type typed_want);
      int unsigned depth_was;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= {code, eos};
      @(posedge clock);
      while (req_full) @(posedge clock);
      depth_was = pending_bytes.size();
      encode_item(code, eos);
      // A typed-in result replaces the computed one; the state still advances.
      if (typed) begin
         while (pending_bytes.size() > depth_was) pending_bytes.pop_back();
         pending_bytes.push_back(typed_want);
      end
   endtask

   // Let the block go idle, including items that produce nothing.
   task automatic drain();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input bit val);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_ALLOW_PAIRS)
         allow_q = val;
      else
         per_item_q = val;
   endtask

   function automatic logic [31:0] valid_code();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom_range(1, 'h7F);
         2: return $urandom_range('h80, 'h7FF);
         3: return $urandom_range('h800, 'hD7FF);
         4: return $urandom_range('hE000, 'hFFFF);
         default: return $urandom_range('h1_0000, 'h10_FFFF);
      endcase
   endfunction

   function automatic logic [31:0] any_code();
      case ($urandom_range(0, 4))
         0: return valid_code();
         1: return HIGH_FIRST + $urandom_range(0, 1023);
         2: return LOW_FIRST + $urandom_range(0, 1023);
         3: return $urandom();
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return CP_MAX + 1;
               2: return 32'hFFFF_FFFF;
               3: return 32'h7FFF_FFFF;
               default: return CP_MAX;
            endcase
         end
      endcase
   endfunction

   // One register setting, then random items under it.
   task automatic run_phase(input bit allow, input bit per_item, input int unsigned n_items);
      logic [31:0] codes [$];
      int unsigned sent;
      int unsigned len;
      write_reg(CSR_ALLOW_PAIRS, allow);
      write_reg(CSR_PER_ITEM, per_item);
      sent = 0;
      while (sent < n_items) begin
         if (per_item_q) begin
            send_item($urandom_range(0, 1) ? any_code() : valid_code(),
                      1'($urandom_range(0, 1)), 1'b0, NO_WANT);
            sent++;
         end else if ($urandom_range(0, 4) != 0) begin
            // Well-formed string, now and then with one item spoiled.
            codes.delete();
            len = $urandom_range(1, 6);
            repeat (len) begin
               if (allow_q && $urandom_range(0, 3) == 0) begin
                  codes.push_back(HIGH_FIRST + $urandom_range(0, 1023));
                  codes.push_back(LOW_FIRST + $urandom_range(0, 1023));
               end else begin
                  codes.push_back(valid_code());
               end
            end
            if ($urandom_range(0, 9) == 0)
               codes[$urandom_range(0, codes.size() - 1)] = any_code();
            foreach (codes[k])
               send_item(codes[k], k == codes.size() - 1, 1'b0, NO_WANT);
            sent += codes.size();
         end else begin
            // Noise: arbitrary values with arbitrary string ends.
            repeat ($urandom_range(1, 4)) begin
               send_item(any_code(), $urandom_range(0, 2) == 0, 1'b0, NO_WANT);
               sent++;
            end
         end
      end
   endtask

   task automatic add_row(input row_kind_type kind, input logic [31:0] code, input bit eos,
                          input bit typed, input rsp_type typed_want);
      dir_rows.push_back('{kind, code, eos, typed, typed_want});
   endtask

   task automatic load_directed();
      // String mode, pairing off, as after reset.
      add_row(ROW_ITEM, 32'h41, 1'b1, 1'b1, {8'h41, 1'b1, 1'b1, 1'b0, 1'b1});
      add_row(ROW_ITEM, 32'h0, 1'b1, 1'b1, EMPTY_CLOSE);
      add_row(ROW_ITEM, 32'h0, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h7F, 1'b0, 1'b1, {8'h7F, 1'b1, 1'b1, 1'b0, 1'b0});
      add_row(ROW_ITEM, 32'h80, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h7FF, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h800, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'hFFFF, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h1_0000, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h10_FFFF, 1'b1, 1'b0, NO_WANT);
      // High surrogate with pairing off, then a lone low one that taints
      // the rest of its string.
      add_row(ROW_ITEM, 32'hD800, 1'b1, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'hDC00, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h41, 1'b1, 1'b1, BAD_CLOSE);
      // Out of range, the NA marker and a plain negative value.
      add_row(ROW_ITEM, 32'h11_0000, 1'b1, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, BAD_CLOSE);
      // Pairing on: a good pair, a high followed by a non-low, a high that
      // ends its string.
      add_row(ROW_ALLOW, 32'h1, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'hDBFF, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'hDFFF, 1'b1, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'hD800, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h41, 1'b1, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'hD800, 1'b1, 1'b1, BAD_CLOSE);
      // A held high surrogate still pairs after pairing is switched off.
      add_row(ROW_ITEM, 32'hD83D, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ALLOW, 32'h0, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'hDE00, 1'b1, 1'b0, NO_WANT);
      // Leave the error latched, then per-item mode must start clean.
      add_row(ROW_ITEM, 32'hDC00, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_MODE, 32'h1, 1'b0, 1'b0, NO_WANT);
      add_row(ROW_ITEM, 32'h41, 1'b0, 1'b1, {8'h41, 1'b1, 1'b1, 1'b0, 1'b1});
      add_row(ROW_ITEM, 32'h0, 1'b0, 1'b1, EMPTY_CLOSE);
      add_row(ROW_ITEM, 32'hD800, 1'b1, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, BAD_CLOSE);
      add_row(ROW_ITEM, 32'h10_FFFF, 1'b0, 1'b0, NO_WANT);
   endtask

   initial begin
      int unsigned waited;
      load_directed();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         case (dir_rows[k].kind)
            ROW_ITEM:  send_item(dir_rows[k].code, dir_rows[k].eos,
                                 dir_rows[k].typed, dir_rows[k].want);
            ROW_ALLOW: write_reg(CSR_ALLOW_PAIRS, dir_rows[k].code[0]);
            default:   write_reg(CSR_PER_ITEM, dir_rows[k].code[0]);
         endcase
      end

      run_phase(1'b1, 1'b0, PHASE_ITEMS);
      run_phase(1'b0, 1'b0, PHASE_ITEMS);
      run_phase(1'b1, 1'b1, PHASE_ITEMS);
      run_phase(1'b0, 1'b1, PHASE_ITEMS);
      run_phase(1'b1, 1'b0, PHASE_ITEMS);
      // Last stretch at full rate on both sides.
      idle_on = 1'b0;
      run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), PHASE_ITEMS);

      req_push <= 1'b0;
      waited = 0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0)
         flag_mismatch("results never delivered", pending_bytes.size(), 0);

      if (mismatch_count == 0) begin
         $display("[utf8_encoder_with_surrogate_pairs_core] OK");
      end else begin
         $display("[utf8_encoder_with_surrogate_pairs_core] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/utfe_pkg.sv
sv/utfe_front.sv
sv/utfe_queue.sv
sv/utfe_back.sv
sv/utf8_encoder_with_surrogate_pairs_core.sv
test/tb_utf8_encoder_with_surrogate_pairs_core.sv
